FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked by clk_i and disabled
// while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define SBCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sbcu_pkg.sv
// ---------------------------------------------------------------------------
// sbcu_pkg
// Types and constants shared by the six-bit code unpacker modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbcu_pkg;

  localparam int unsigned CodeW        = 6;
  localparam int unsigned CharW        = 8;
  localparam int unsigned TblWords     = 8;
  localparam int unsigned TblIdxW      = $clog2(TblWords);
  localparam int unsigned CfgIdxW      = TblIdxW + 1;
  localparam int unsigned CfgDataW     = 64;

  localparam logic [CodeW-1:0] TermCode = 6'h3F;

  // Request kinds on the input channel.
  localparam logic KindData    = 1'b0;
  localparam logic KindRestart = 1'b1;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [CharW-1:0] char_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } sbcu_in_t;

  typedef struct packed {
    char_t char_out;
    logic  end_marker;
    logic  last;
  } sbcu_out_t;

  // Results of one decoded byte, handed to the result buffer.
  typedef struct packed {
    logic       load;
    logic [1:0] count;
    sbcu_out_t  res0;
    sbcu_out_t  res1;
  } sbcu_load_t;

endpackage

`default_nettype wire

FILE: rtl/six_bit_code_unpacker.sv
// ---------------------------------------------------------------------------
// six_bit_code_unpacker
// Unpacks bytes carrying four 6-bit codes per three bytes and maps each code
// to a character through a configurable 64-entry table.
// ---------------------------------------------------------------------------
//
//   Channel   Signals                                    Carries
//   in        in_valid_i / in_ready_o / in_req_i         kind, byte_in
//   out       out_valid_o / out_ready_i / out_req_o      char_out, end_marker, last
//   cfg       cfg_valid_i / cfg_ready_o / cfg_index_i,   table word index and data
//             cfg_data_i
//
// Each request waits in the input register until the result buffer has room for
// its results; they are then written to the result register and presented from
// there in order. A byte that completes two codes presents them one after the
// other on the single result port, and the next byte leaves the input register
// only once the buffer drains, so the port sets the sustained rate. Reset clears
// the stream state and the table words at once; there is no clearing pass. While
// results are stalled the input register still takes one further request.
`timescale 1ns / 1ps
`default_nettype none

module six_bit_code_unpacker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sbcu_pkg::sbcu_in_t            in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sbcu_pkg::sbcu_out_t                out_req_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sbcu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sbcu_pkg::CfgDataW-1:0] cfg_data_i
);
  import sbcu_pkg::*;

  code_t      code_a, code_b;
  char_t      char_a, char_b;
  sbcu_load_t load;
  logic       room;

  // The table answers both code lookups of the byte in the input register.
  sbcu_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .code_a_i    (code_a),
    .code_b_i    (code_b),
    .char_a_o    (char_a),
    .char_b_o    (char_b)
  );

  // The decoder keeps phase, leftover bits and the terminator flag, and
  // advances them only when the byte's results can be written.
  sbcu_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .room_i     (room),
    .code_a_o   (code_a),
    .code_b_o   (code_b),
    .char_a_i   (char_a),
    .char_b_i   (char_b),
    .load_o     (load)
  );

  // The result buffer presents the one or two results in order.
  sbcu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

FILE: rtl/sbcu_table.sv
// ---------------------------------------------------------------------------
// sbcu_table
// Character table registers with two combinational lookup ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbcu_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sbcu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sbcu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire sbcu_pkg::code_t                code_a_i,
  input  wire sbcu_pkg::code_t                code_b_i,
  output sbcu_pkg::char_t                     char_a_o,
  output sbcu_pkg::char_t                     char_b_o
);
  import sbcu_pkg::*;

  logic [CfgDataW-1:0] table_q [TblWords];
  logic                wr_en;

  assign cfg_ready_o = 1'b1;
  // Indexes past the last table word are dropped.
  assign wr_en = cfg_valid_i && !cfg_index_i[CfgIdxW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TblWords; i++) begin
        table_q[i] <= '0;
      end
    end else if (wr_en) begin
      table_q[cfg_index_i[TblIdxW-1:0]] <= cfg_data_i;
    end
  end

  // Code 8k+j sits in byte j of word k.
  assign char_a_o = table_q[code_a_i[5:3]][{code_a_i[2:0], 3'b000} +: CharW];
  assign char_b_o = table_q[code_b_i[5:3]][{code_b_i[2:0], 3'b000} +: CharW];

endmodule

`default_nettype wire

FILE: rtl/sbcu_decode.sv
// ---------------------------------------------------------------------------
// sbcu_decode
// Input register, stream state and extraction of the codes of one byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbcu_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sbcu_pkg::sbcu_in_t in_req_i,
  input  wire logic               room_i,
  output sbcu_pkg::code_t         code_a_o,
  output sbcu_pkg::code_t         code_b_o,
  input  wire sbcu_pkg::char_t    char_a_i,
  input  wire sbcu_pkg::char_t    char_b_i,
  output sbcu_pkg::sbcu_load_t    load_o
);
  import sbcu_pkg::*;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_e;

  sbcu_in_t   in_q;
  logic       in_valid_q;
  logic       move;
  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       done_q, done_d;
  logic       term_a, term_b;
  logic [7:0] b;

  // The held byte moves on once the result buffer has room for both results.
  assign move       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;
  assign b          = in_q.byte_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      left_q  <= '0;
      done_q  <= 1'b0;
    end else if (move) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    case (phase_q)
      PH_1:    code_a_o = {left_q[1:0], b[7:4]};
      PH_2:    code_a_o = {left_q, b[7:6]};
      default: code_a_o = b[7:2];
    endcase
  end

  assign code_b_o = b[5:0];
  assign term_a   = (code_a_o == TermCode);
  assign term_b   = (code_b_o == TermCode);

  always_comb begin
    phase_d      = phase_q;
    left_d       = left_q;
    done_d       = done_q;
    load_o       = '0;
    load_o.load  = move;
    if (in_q.kind == KindRestart) begin
      phase_d = PH_0;
      left_d  = '0;
      done_d  = 1'b0;
    end else if (!done_q) begin
      if (term_a) begin
        load_o.count = 2'd1;
        load_o.res0  = '{char_out: '0, end_marker: 1'b1, last: 1'b1};
        done_d       = 1'b1;
      end else begin
        case (phase_q)
          PH_1: begin
            load_o.count = 2'd1;
            load_o.res0  = '{char_out: char_a_i, end_marker: 1'b0, last: 1'b1};
            left_d       = b[3:0];
            phase_d      = PH_2;
          end
          PH_2: begin
            load_o.count = 2'd2;
            load_o.res0  = '{char_out: char_a_i, end_marker: 1'b0, last: 1'b0};
            if (term_b) begin
              load_o.res1 = '{char_out: '0, end_marker: 1'b1, last: 1'b1};
              done_d      = 1'b1;
            end else begin
              load_o.res1 = '{char_out: char_b_i, end_marker: 1'b0, last: 1'b1};
              left_d      = '0;
              phase_d     = PH_0;
            end
          end
          default: begin
            load_o.count = 2'd1;
            load_o.res0  = '{char_out: char_a_i, end_marker: 1'b0, last: 1'b1};
            left_d       = {2'b00, b[1:0]};
            phase_d      = PH_1;
          end
        endcase
      end
    end
  end

  `SBCU_ASSERT(a_phase_legal, phase_q != 2'd3, "phase counter left its range")
  `SBCU_ASSERT(a_done_silent, !(move && done_q && in_q.kind == KindData) || load_o.count == 2'd0,
    "data byte after terminator produced results")
  `SBCU_ASSERT_NEXT(a_term_sets_done,
    move && (load_o.res0.end_marker || (load_o.count == 2'd2 && load_o.res1.end_marker)),
    done_q, "terminator did not close the stream")

endmodule

`default_nettype wire

FILE: rtl/sbcu_out_buf.sv
// ---------------------------------------------------------------------------
// sbcu_out_buf
// Two-slot result register that serialises the results of one byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbcu_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sbcu_pkg::sbcu_load_t load_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output sbcu_pkg::sbcu_out_t       out_req_o
);
  import sbcu_pkg::*;

  logic [1:0] count_q, count_d;
  sbcu_out_t  head_q, head_d;
  sbcu_out_t  tail_q, tail_d;
  logic       fire;

  assign out_valid_o = (count_q != 2'd0);
  assign out_req_o   = head_q;
  assign fire        = out_valid_o && out_ready_i;
  // Room for a fresh pair once the buffer is empty at the end of this cycle.
  assign room_o      = (count_q == 2'd0) || (count_q == 2'd1 && out_ready_i);

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (load_i.load) begin
      count_d = load_i.count;
      head_d  = load_i.res0;
      tail_d  = load_i.res1;
    end else if (fire) begin
      count_d = count_q - 2'd1;
      head_d  = tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  `SBCU_ASSERT(a_count_range, count_q != 2'd3, "result count out of range")
  `SBCU_ASSERT(a_load_room, !load_i.load || room_o, "results loaded over pending results")
  `SBCU_ASSERT_NEXT(a_pair_drain, fire && count_q == 2'd2 && !load_i.load,
    count_q == 2'd1, "second result of a pair lost")

endmodule

`default_nettype wire
